// File: rtl/aesenc_pkg.sv
// Shared types, constants and functions for the AES-128 encryption core.
package aesenc_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned ROUNDS = 10;
    localparam int unsigned RND_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH   = 3'd0,
        REG_KEY_LOW    = 3'd1,
        REG_IV_HIGH    = 3'd2,
        REG_IV_LOW     = 3'd3,
        REG_CHAIN_MODE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [127:0] block;
        logic         restart;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte b of a 128-bit block, byte 0 most significant
    function automatic logic [7:0] get_b(input logic [127:0] s, input int b);
        return s[127-8*b -: 8];
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0]   t [4];
        logic [127:0] o;
        logic [7:0]   acc;
        for (int r = 0; r < 4; r++) t[r] = sbox(get_b(k, ((r + 1) % 4) * 4 + 3));
        t[0] = t[0] ^ rc;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            acc = get_b(k, r*4) ^ t[r];
            o[127-8*(r*4) -: 8] = acc;
            for (int c = 1; c < 4; c++) begin
                acc = acc ^ get_b(k, r*4+c);
                o[127-8*(r*4+c) -: 8] = acc;
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r*4+c] = sbox(get_b(s, r*4 + ((c + r) % 4)));
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = t[c]; a1 = t[4+c]; a2 = t[8+c]; a3 = t[12+c];
            if (last) begin
                o[127-8*c -: 8]      = a0;
                o[127-8*(4+c) -: 8]  = a1;
                o[127-8*(8+c) -: 8]  = a2;
                o[127-8*(12+c) -: 8] = a3;
            end else begin
                o[127-8*c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[127-8*(4+c) -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[127-8*(8+c) -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[127-8*(12+c) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return o;
    endfunction
endpackage

// File: rtl/aesenc_plain_if.sv
// Input channel: plaintext beat with chain restart flag.
interface aesenc_plain_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        restart_chain;
    modport source(output valid, plain_high, plain_low, restart_chain, input ready);
    modport sink(input valid, plain_high, plain_low, restart_chain, output ready);
endinterface

// File: rtl/aesenc_cipher_if.sv
// Output channel: ciphertext beat.
interface aesenc_cipher_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source(output valid, cipher_high, cipher_low, input ready);
    modport sink(input valid, cipher_high, cipher_low, output ready);
endinterface

// File: rtl/aes128_block_encrypt_core.sv
// AES-128 block encryption core, ECB or CBC, one block per plaintext beat.
// Usage:
//   Write key, IV and chain mode through the config port while idle
//   (index 0 key high, 1 key low, 2 IV high, 3 IV low, 4 mode).
//   Send plaintext beats on s_in (valid/ready); ciphertext beats leave on
//   m_out (valid/ready), one per plaintext beat, in order.
// An accepted block is loaded into the round state register and retires into the output register.
// Throughput is set by the single shared round unit
//   (initial key add in the load cycle, then ten rounds, one round and one
//   key step a cycle; the next block loads as the last round retires).
// A two-entry queue parts the front from the round engine; the output
//   register lets the next block run while a result waits.
// Reset: clears control, queue, chain value and all config registers.
// When the receiver stalls, the finished block waits in the output register;
//   the engine holds its last round, then the queue fills and s_in.ready drops.
module aes128_block_encrypt_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [aesenc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aesenc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    aesenc_plain_if.sink                         s_in,
    aesenc_cipher_if.source                      m_out
);
    import aesenc_pkg::*;

    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic        r_cbc;
    t_job        w_job;
    logic        w_job_valid, w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
            r_cbc    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_KEY_HIGH:   r_key_hi <= i_cfg_data;
                REG_KEY_LOW:    r_key_lo <= i_cfg_data;
                REG_IV_HIGH:    r_iv_hi  <= i_cfg_data;
                REG_IV_LOW:     r_iv_lo  <= i_cfg_data;
                REG_CHAIN_MODE: r_cbc    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    aesenc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .o_job(w_job), .o_job_valid(w_job_valid), .i_job_take(w_take)
    );

    aesenc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job(w_job), .i_job_valid(w_job_valid), .o_job_take(w_take),
        .i_key({r_key_hi, r_key_lo}), .i_iv({r_iv_hi, r_iv_lo}), .i_cbc(r_cbc),
        .m_out(m_out)
    );
endmodule

// File: rtl/aesenc_front.sv
// Front end: takes plaintext beats into a two-entry job queue.
module aesenc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aesenc_plain_if.sink          s_in,
    output aesenc_pkg::t_job      o_job,
    output logic                  o_job_valid,
    input  logic                  i_job_take
);
    import aesenc_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign s_in.ready  = (r_cnt != 2'd2);
    assign w_push      = s_in.valid && s_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{block: {s_in.plain_high, s_in.plain_low},
                           restart: s_in.restart_chain};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_job_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_job_take};
        end
    end

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_take |-> o_job_valid)
        else $error("job taken from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt != 2'd2))
        else $error("beat pushed into full queue");
endmodule

// File: rtl/aesenc_back.sv
// Back end: iterative AES-128 round engine with on-the-fly key schedule and CBC chaining.
module aesenc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aesenc_pkg::t_job  i_job,
    input  logic              i_job_valid,
    output logic              o_job_take,
    input  logic [127:0]      i_key,
    input  logic [127:0]      i_iv,
    input  logic              i_cbc,
    aesenc_cipher_if.source   m_out
);
    import aesenc_pkg::*;

    logic               r_busy;
    logic [RND_W-1:0]   r_rnd;
    logic [127:0]       r_s, r_k, r_chain;
    logic [7:0]         r_rc;
    logic               r_ov;
    logic [127:0]       r_out;
    logic [127:0]       w_x, w_nk, w_ns, w_chain_in;
    logic               w_last, w_done, w_start, w_retire;

    assign w_last  = (r_rnd == RND_W'(ROUNDS));
    assign w_done  = r_busy && w_last;
    // a result may retire into the output register when it is free or leaving
    assign w_retire = w_done && (!r_ov || m_out.ready);
    assign w_start = i_job_valid && (!r_busy || w_retire);
    assign o_job_take = w_start;

    always_comb begin
        w_nk = next_key(r_k, r_rc);
        w_ns = enc_round(r_s, w_last) ^ w_nk;
        // forward the ciphertext retiring in this cycle as the chain value
        if (i_job.restart) begin
            w_chain_in = i_iv;
        end else if (w_retire && i_cbc) begin
            w_chain_in = w_ns;
        end else begin
            w_chain_in = r_chain;
        end
        w_x  = i_job.block ^ (i_cbc ? w_chain_in : 128'd0);
    end

    assign m_out.valid       = r_ov;
    assign m_out.cipher_high = r_out[127:64];
    assign m_out.cipher_low  = r_out[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            r_rnd   <= '0;
            r_chain <= '0;
        end else begin
            if (m_out.ready) r_ov <= 1'b0;
            if (w_retire) begin
                r_out <= w_ns;
                r_ov  <= 1'b1;
                if (i_cbc) r_chain <= w_ns;
            end
            if (w_start) begin
                // restart of the next block follows the retiring block's chain update
                if (i_job.restart) r_chain <= i_iv;
                r_busy <= 1'b1;
                r_rnd  <= RND_W'(1);
                r_s    <= w_x ^ i_key;
                r_k    <= i_key;
                r_rc   <= 8'h01;
            end else if (w_retire) begin
                r_busy <= 1'b0;
            end else if (r_busy && !w_last) begin
                r_rnd <= r_rnd + RND_W'(1);
                r_s   <= w_ns;
                r_k   <= w_nk;
                r_rc  <= xtime(r_rc);
            end
        end
    end

    a_rnd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rnd != '0))
        else $error("busy at round zero");
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_start && r_busy) |-> w_retire)
        else $error("start while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> (r_ov && $stable(r_out)))
        else $error("output beat changed while stalled");
endmodule
